// ----- src/hpr_pkg.sv -----
package hpr_pkg;

  // field widths
  localparam int AngleW  = 16;
  localparam int GainW   = 16;
  localparam int ThreshW = 15;
  localparam int SpeedW  = 24;
  localparam int IntegW  = 32;
  localparam int CfgIdxW = 3;
  localparam int CfgDatW = 16;

  // product and sum widths
  localparam int PProdW = GainW + 1 + AngleW;        // 33
  localparam int IProdW = GainW + 1 + IntegW;        // 49
  localparam int DProdW = GainW + 1 + AngleW + 1;    // 34
  localparam int SumW   = IProdW + 1;                // 50
  localparam int ShiftW = SumW - 8;                  // 42

  // register indexes
  localparam logic [CfgIdxW-1:0] RegTarget    = 3'd0;
  localparam logic [CfgIdxW-1:0] RegGainP     = 3'd1;
  localparam logic [CfgIdxW-1:0] RegGainI     = 3'd2;
  localparam logic [CfgIdxW-1:0] RegGainD     = 3'd3;
  localparam logic [CfgIdxW-1:0] RegThreshold = 3'd4;

  // reset values
  localparam logic [AngleW-1:0]  TargetRst    = 16'd0;
  localparam logic [GainW-1:0]   GainPRst     = 16'd5120;
  localparam logic [GainW-1:0]   GainIRst     = 16'd0;
  localparam logic [GainW-1:0]   GainDRst     = 16'd640;
  localparam logic [ThreshW-1:0] ThresholdRst = 15'd18022;

  // speed limits
  localparam logic signed [SpeedW-1:0] SpeedMax = 24'sh7FFFFF;
  localparam logic signed [SpeedW-1:0] SpeedMin = 24'sh800000;
  localparam logic signed [IntegW-1:0] IntegMax = 32'sh7FFFFFFF;
  localparam logic signed [IntegW-1:0] IntegMin = 32'sh80000000;

  // queue
  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  // classified item between front and back
  typedef struct packed {
    logic                     reversed;
    logic signed [AngleW-1:0] err;
  } hpr_item_t;

  // gains seen by the back end
  typedef struct packed {
    logic [GainW-1:0] gain_p;
    logic [GainW-1:0] gain_i;
    logic [GainW-1:0] gain_d;
  } hpr_gains_t;

endpackage

// ----- src/hpr_front.sv -----
module hpr_front
  import hpr_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDatW-1:0]  cfg_data,
  input  logic [AngleW-1:0]   heading,
  output hpr_item_t           item,
  output hpr_gains_t          gains
);

  logic [AngleW-1:0]  target_angle;
  logic [GainW-1:0]   gain_p;
  logic [GainW-1:0]   gain_i;
  logic [GainW-1:0]   gain_d;
  logic [ThreshW-1:0] reverse_threshold;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      target_angle      <= TargetRst;
      gain_p            <= GainPRst;
      gain_i            <= GainIRst;
      gain_d            <= GainDRst;
      reverse_threshold <= ThresholdRst;
    end else if (cfg_we) begin
      case (cfg_index)
        RegTarget:    target_angle      <= cfg_data[AngleW-1:0];
        RegGainP:     gain_p            <= cfg_data[GainW-1:0];
        RegGainI:     gain_i            <= cfg_data[GainW-1:0];
        RegGainD:     gain_d            <= cfg_data[GainW-1:0];
        RegThreshold: reverse_threshold <= cfg_data[ThreshW-1:0];
        default: ;
      endcase
    end
  end

  assign gains = '{gain_p: gain_p, gain_i: gain_i, gain_d: gain_d};

  logic [AngleW-1:0] diff;
  logic [AngleW-1:0] mag;
  logic              flip;

  // wrapped error, magnitude and front reversal
  always_comb begin
    diff = heading - target_angle;
    mag  = diff[AngleW-1] ? (~diff + 1'b1) : diff;
    flip = mag > {1'b0, reverse_threshold};
    item.reversed = flip;
    // adding half a turn only toggles the top bit
    item.err = flip ? $signed({~diff[AngleW-1], diff[AngleW-2:0]}) : $signed(diff);
  end

endmodule

// ----- src/hpr_queue.sv -----
module hpr_queue
  import hpr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  hpr_item_t push_item,
  output logic      full,
  input  logic      pop,
  output logic      empty,
  output hpr_item_t pop_item
);

  hpr_item_t         mem [QDepth];
  logic [QPtrW-1:0]  wr_ptr;
  logic [QPtrW-1:0]  rd_ptr;
  logic [QCntW-1:0]  count;

  assign full     = count == QCntW'(QDepth);
  assign empty    = count == '0;
  assign pop_item = mem[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- src/hpr_back.sv -----
module hpr_back
  import hpr_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  hpr_gains_t               gains,
  input  logic                     q_empty,
  input  hpr_item_t                q_item,
  output logic                     q_pop,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [SpeedW-1:0] left_speed,
  output logic signed [SpeedW-1:0] right_speed,
  output logic                     front_reversed
);

  // controller state
  logic signed [AngleW-1:0] previous_error;
  logic signed [IntegW-1:0] error_integral;

  // product stage
  logic                     s1_valid;
  logic                     s1_rev;
  logic signed [PProdW-1:0] s1_p;
  logic signed [IProdW-1:0] s1_i;
  logic signed [DProdW-1:0] s1_d;

  logic out_free;
  logic s1_free;

  assign out_free = !out_valid || out_ready;
  assign s1_free  = !s1_valid || out_free;
  assign q_pop    = !q_empty && s1_free;

  // multiplies and next state
  logic signed [GainW:0]    gp_s;
  logic signed [GainW:0]    gi_s;
  logic signed [GainW:0]    gd_s;
  logic signed [AngleW:0]   err_diff;
  logic signed [PProdW-1:0] p_next;
  logic signed [IProdW-1:0] i_next;
  logic signed [DProdW-1:0] d_next;
  logic signed [IntegW:0]   acc;
  logic signed [IntegW-1:0] integral_next;

  always_comb begin
    gp_s     = $signed({1'b0, gains.gain_p});
    gi_s     = $signed({1'b0, gains.gain_i});
    gd_s     = $signed({1'b0, gains.gain_d});
    err_diff = $signed({q_item.err[AngleW-1], q_item.err})
             - $signed({previous_error[AngleW-1], previous_error});
    p_next   = gp_s * q_item.err;
    i_next   = gi_s * error_integral;
    d_next   = gd_s * err_diff;
    acc      = $signed({error_integral[IntegW-1], error_integral})
             + $signed({{(IntegW-AngleW+1){q_item.err[AngleW-1]}}, q_item.err});
    if (acc[IntegW] != acc[IntegW-1]) begin
      integral_next = acc[IntegW] ? IntegMin : IntegMax;
    end else begin
      integral_next = acc[IntegW-1:0];
    end
  end

  // state update on every item taken from the queue
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_error <= '0;
      error_integral <= '0;
    end else if (q_pop) begin
      previous_error <= q_item.err;
      error_integral <= integral_next;
    end
  end

  // product registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= q_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_p   <= p_next;
      s1_i   <= i_next;
      s1_d   <= d_next;
      s1_rev <= q_item.reversed;
    end
  end

  // sum, scale, saturate and split to the wheels
  logic signed [SumW-1:0]   sum;
  logic signed [ShiftW-1:0] scaled;
  logic signed [SpeedW-1:0] speed;
  logic signed [SpeedW-1:0] speed_neg;
  logic signed [SpeedW-1:0] left_next;
  logic signed [SpeedW-1:0] right_next;

  always_comb begin
    sum = $signed({{(SumW-PProdW){s1_p[PProdW-1]}}, s1_p})
        + $signed({{(SumW-IProdW){s1_i[IProdW-1]}}, s1_i})
        + $signed({{(SumW-DProdW){s1_d[DProdW-1]}}, s1_d});
    // floor division by 256
    scaled = sum[SumW-1:8];
    if (scaled[ShiftW-1:SpeedW-1] == '0 || scaled[ShiftW-1:SpeedW-1] == '1) begin
      speed = scaled[SpeedW-1:0];
    end else begin
      speed = scaled[ShiftW-1] ? SpeedMin : SpeedMax;
    end
    speed_neg = (speed == SpeedMin) ? SpeedMax : -speed;
    left_next  = s1_rev ? speed_neg : speed;
    right_next = s1_rev ? speed : speed_neg;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid) begin
      left_speed     <= left_next;
      right_speed    <= right_next;
      front_reversed <= s1_rev;
    end
  end

endmodule

// ----- src/heading_pid_rotate_unit.sv -----
// channel   | direction | contents
// ----------+-----------+------------------------------------------------------
// s_axis    | in        | tdata[15:0] heading
// m_axis    | out       | tdata[23:0] left_speed, [47:24] right_speed;
//           |           | tuser[0] front_reversed
// cfg       | in        | cfg_we, cfg_index (0..4), cfg_data[15:0]
//
// one heading is taken per cycle and one result leaves per cycle when m_tready
// stays high; a result passes through a queue entry, the product register and the
// output register before it is offered.
// rst is synchronous and restores the gains, the threshold and the controller state.
// s_tready falls only when the four-entry queue between front and back is full,
// so a stalled output backs up through the queue before the input stalls.
module heading_pid_rotate_unit
  import hpr_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [15:0]         s_tdata,   // heading
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [47:0]         m_tdata,   // left_speed, right_speed
  output logic [0:0]          m_tuser,   // front_reversed
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDatW-1:0]  cfg_data
);

  hpr_item_t  front_item;
  hpr_item_t  back_item;
  hpr_gains_t gains;
  logic       q_full;
  logic       q_empty;
  logic       q_pop;
  logic       push;

  logic signed [SpeedW-1:0] left_speed;
  logic signed [SpeedW-1:0] right_speed;
  logic                     front_reversed;

  assign s_tready = !q_full;
  assign push     = s_tvalid && !q_full;

  // error and reversal classification
  hpr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .heading   (s_tdata[AngleW-1:0]),
    .item      (front_item),
    .gains     (gains)
  );

  // decoupling queue
  hpr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (front_item),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .pop_item  (back_item)
  );

  // pid datapath
  hpr_back u_back (
    .clk            (clk),
    .rst            (rst),
    .gains          (gains),
    .q_empty        (q_empty),
    .q_item         (back_item),
    .q_pop          (q_pop),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .left_speed     (left_speed),
    .right_speed    (right_speed),
    .front_reversed (front_reversed)
  );

  assign m_tdata = {right_speed, left_speed};
  assign m_tuser = front_reversed;

endmodule
